/* rtl/lkv_pkg.sv */
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int DEPTH   = 16;
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;

   // Capacity register width is fixed by the register map.
   localparam int CAP_W   = 5;
   localparam int RANK_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int EXT_W   = (CAP_W > CNT_W) ? CAP_W + 1 : CNT_W + 1;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [RANK_W-1:0]  rank_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [DEPTH-1:0]   sel_type;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_SET = 1'b1
   } op_type;

   typedef struct packed {
      logic    hit;
      sel_type hit_sel;
      logic    free_found;
      sel_type free_sel;
      sel_type lru_sel;
   } lookup_type;

endpackage

/* rtl/lkv_lookup.sv */
`timescale 1ns / 1ps

module lkv_lookup (
   input  lkv_pkg::key_type    key,
   input  lkv_pkg::sel_type    valid,
   input  lkv_pkg::key_type    keys [lkv_pkg::DEPTH],
   input  lkv_pkg::rank_type   ranks [lkv_pkg::DEPTH],
   input  lkv_pkg::count_type  entries_used,
   output lkv_pkg::lookup_type result
);

   lkv_pkg::sel_type   match;
   lkv_pkg::sel_type   free;
   lkv_pkg::count_type used_m1;

   assign used_m1 = entries_used - lkv_pkg::count_type'(1);

   always_comb begin
      for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
         match[i]          = valid[i] && (keys[i] == key);
         // Valid ranks are always 0 .. entries_used-1, so the oldest entry
         // is the one holding the top rank.
         result.lru_sel[i] = valid[i] && (ranks[i] == used_m1[lkv_pkg::RANK_W-1:0]);
      end
      free              = ~valid;
      result.hit        = |match;
      result.hit_sel    = match & (~match + lkv_pkg::sel_type'(1));
      result.free_found = |free;
      result.free_sel   = free & (~free + lkv_pkg::sel_type'(1));
   end

endmodule

/* rtl/lru_key_value_cache.sv */
`timescale 1ns / 1ps

// Throughput: one request per cycle while each response is taken as it is produced; the
// lookup, rank update and entry write all act on the request register and are stored with the response.
// Reset (synchronous) clears all valid bits, ranks and the fill count at once
// and sets the capacity to 16; keys and values are not cleared.
module lru_key_value_cache (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  lkv_pkg::key_type     req_key,
   input  lkv_pkg::value_type   req_write_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output lkv_pkg::value_type   rsp_read_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [lkv_pkg::CAP_W-1:0] csr_write_data
);

   logic                        in_valid_ff, in_valid_in;
   lkv_pkg::op_type             in_op_ff;
   lkv_pkg::key_type            in_key_ff;
   lkv_pkg::value_type          in_wval_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   lkv_pkg::value_type          rsp_value_ff, rsp_value_in;

   logic [lkv_pkg::CAP_W-1:0]   cap_ff;

   lkv_pkg::sel_type            valid_ff, valid_in;
   lkv_pkg::rank_type           rank_ff [lkv_pkg::DEPTH];
   lkv_pkg::rank_type           rank_in [lkv_pkg::DEPTH];
   lkv_pkg::key_type            key_ff  [lkv_pkg::DEPTH];
   lkv_pkg::value_type          value_ff [lkv_pkg::DEPTH];
   lkv_pkg::count_type          used_ff, used_in;

   lkv_pkg::lookup_type         look;
   logic                        process;
   logic                        is_set;
   logic                        full;
   logic                        fill;
   logic                        do_promote;
   logic                        write_key;
   logic                        write_value;
   lkv_pkg::sel_type            target;
   lkv_pkg::rank_type           target_rank;
   logic [lkv_pkg::RANK_W:0]    threshold;
   lkv_pkg::value_type          hit_value;
   logic [lkv_pkg::EXT_W-1:0]   eff_cap;
   logic [lkv_pkg::EXT_W-1:0]   used_ext;

   assign process   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || process;
   assign csr_ready = 1'b1;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;

   lkv_lookup u_lookup (
      .key          (in_key_ff),
      .valid        (valid_ff),
      .keys         (key_ff),
      .ranks        (rank_ff),
      .entries_used (used_ff),
      .result       (look)
   );

   always_comb begin
      // A capacity of zero behaves as one, and anything above the depth as the depth.
      if (cap_ff == '0) begin
         eff_cap = lkv_pkg::EXT_W'(1);
      end else if (lkv_pkg::EXT_W'(cap_ff) > lkv_pkg::EXT_W'(lkv_pkg::DEPTH)) begin
         eff_cap = lkv_pkg::EXT_W'(lkv_pkg::DEPTH);
      end else begin
         eff_cap = lkv_pkg::EXT_W'(cap_ff);
      end
      used_ext = lkv_pkg::EXT_W'(used_ff);
      full     = used_ext >= eff_cap;
      is_set   = (in_op_ff == lkv_pkg::OP_SET);

      fill        = 1'b0;
      write_key   = 1'b0;
      write_value = 1'b0;
      target      = look.hit_sel;
      if (is_set) begin
         write_value = 1'b1;
         if (!look.hit) begin
            write_key = 1'b1;
            if (full || !look.free_found) begin
               target = look.lru_sel;
            end else begin
               target = look.free_sel;
               fill   = 1'b1;
            end
         end
      end
      do_promote = process && (look.hit || is_set);

      target_rank = '0;
      hit_value   = '0;
      for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
         if (target[i]) begin
            target_rank = target_rank | rank_ff[i];
         end
         if (look.hit_sel[i]) begin
            hit_value = hit_value | value_ff[i];
         end
      end
      // A freshly filled entry ages every valid entry; otherwise only the
      // entries more recent than the one being promoted.
      threshold = fill ? (lkv_pkg::RANK_W+1)'(lkv_pkg::DEPTH)
                       : (lkv_pkg::RANK_W+1)'(target_rank);

      valid_in = valid_ff;
      used_in  = used_ff;
      for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_promote) begin
            if (target[i]) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] &&
                         ((lkv_pkg::RANK_W+1)'(rank_ff[i]) < threshold)) begin
               rank_in[i] = rank_ff[i] + lkv_pkg::rank_type'(1);
            end
         end
      end
      if (process && fill) begin
         valid_in = valid_ff | target;
         used_in  = used_ff + lkv_pkg::count_type'(1);
      end

      rsp_found_in = look.hit;
      rsp_value_in = (!is_set && look.hit) ? hit_value : '0;

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (process) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= lkv_pkg::CAP_RESET;
         valid_ff     <= '0;
         used_ff      <= '0;
         for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
            rank_ff[i] <= rank_in[i];
         end
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= lkv_pkg::op_type'(req_operation);
         in_key_ff  <= req_key;
         in_wval_ff <= req_write_value;
      end
      if (process) begin
         rsp_found_ff <= rsp_found_in;
         rsp_value_ff <= rsp_value_in;
      end
      for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
         if (process && target[i]) begin
            if (write_key) begin
               key_ff[i] <= in_key_ff;
            end
            if (write_value) begin
               value_ff[i] <= in_wval_ff;
            end
         end
      end
   end

   // The fill count always equals the number of valid entries.
   a_used_matches_valid : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(used_ff))
      else $error("fill count differs from number of valid entries");

   // Valid keys are distinct, so at most one entry can match.
   a_single_match : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> $onehot0(look.hit_sel))
      else $error("more than one entry matched the key");

   // Whenever a transfer updates the entries, exactly one entry is chosen.
   a_single_target : assert property (@(posedge clock) disable iff (reset)
      do_promote |-> $onehot(target))
      else $error("update did not select exactly one entry");

   // A processed request always produces a response on the next cycle.
   a_response_follows : assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("processed request produced no response");

endmodule

/* tb/tb_lru_key_value_cache.sv */
`timescale 1ns / 1ps

module tb_lru_key_value_cache;

   typedef struct {
      logic               found;
      lkv_pkg::value_type value;
   } cache_reply_type;

   // Shadow copy of the cache: predicts the reply of every accepted request
   // and compares the replies that come back, in order.
   class cache_shadow;
      bit                       valid_q [lkv_pkg::DEPTH];
      lkv_pkg::key_type         key_q   [lkv_pkg::DEPTH];
      lkv_pkg::value_type       value_q [lkv_pkg::DEPTH];
      int                       rank_q  [lkv_pkg::DEPTH];
      int                       used;
      logic [lkv_pkg::CAP_W-1:0] capacity;
      cache_reply_type          expected_replies [$];
      int                       mismatch_count;

      function new();
         for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
            valid_q[i] = 1'b0;
            rank_q[i]  = 0;
         end
         used           = 0;
         capacity       = lkv_pkg::CAP_RESET;
         mismatch_count = 0;
      endfunction

      function void set_capacity(logic [lkv_pkg::CAP_W-1:0] cap);
         capacity = cap;
      endfunction

      function int outstanding();
         return expected_replies.size();
      endfunction

      function int effective_capacity();
         int c;
         c = int'(capacity);
         if (c == 0) c = 1;
         if (c > lkv_pkg::DEPTH) c = lkv_pkg::DEPTH;
         return c;
      endfunction

      // Every valid entry more recent than the promoted one ages by one.
      function void promote(int e, bit was_valid);
         int r;
         r = was_valid ? rank_q[e] : lkv_pkg::DEPTH;
         for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
            if (i != e && valid_q[i] && rank_q[i] < r) rank_q[i]++;
         end
         rank_q[e] = 0;
      endfunction

      function int least_recent();
         int best;
         bit any;
         best = 0;
         any  = 1'b0;
         for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
            if (valid_q[i] && (!any || rank_q[i] > rank_q[best])) begin
               best = i;
               any  = 1'b1;
            end
         end
         return best;
      endfunction

      function void note_request(lkv_pkg::op_type op, lkv_pkg::key_type k,
                                 lkv_pkg::value_type v);
         int hit;
         int slot;
         cache_reply_type r;
         hit = -1;
         for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
            if (hit < 0 && valid_q[i] && key_q[i] == k) hit = i;
         end
         r.found = (hit >= 0);
         r.value = '0;
         if (op == lkv_pkg::OP_GET) begin
            if (hit >= 0) begin
               r.value = value_q[hit];
               promote(hit, 1'b1);
            end
         end else if (hit >= 0) begin
            value_q[hit] = v;
            promote(hit, 1'b1);
         end else begin
            slot = -1;
            if (used < effective_capacity()) begin
               for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
                  if (slot < 0 && !valid_q[i]) slot = i;
               end
            end
            if (slot < 0) begin
               // Full, or capacity lowered below occupancy: evict the oldest.
               slot = least_recent();
               key_q[slot]   = k;
               value_q[slot] = v;
               promote(slot, 1'b1);
            end else begin
               key_q[slot]   = k;
               value_q[slot] = v;
               promote(slot, 1'b0);
               valid_q[slot] = 1'b1;
               used++;
            end
         end
         expected_replies.push_back(r);
      endfunction

      function void check_reply(logic found, lkv_pkg::value_type value);
         cache_reply_type r;
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply, expected none, actual found %0b value %h",
                     $time, found, value);
            mismatch_count++;
            return;
         end
         r = expected_replies.pop_front();
         if (found !== r.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b", $time, r.found, found);
            mismatch_count++;
         end
         if (value !== r.value) begin
            $display("%0t: read_value mismatch, expected %h, actual %h",
                     $time, r.value, value);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_operation;
   lkv_pkg::key_type          req_key;
   lkv_pkg::value_type        req_write_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_found;
   lkv_pkg::value_type        rsp_read_value;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [lkv_pkg::CAP_W-1:0] csr_write_data;

   cache_shadow      shadow = new();
   bit               hold_off_wanted = 1'b0;
   lkv_pkg::key_type key_pool [24];
   int               pool_size;

   lru_key_value_cache dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_key         (req_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_read_value  (rsp_read_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_write_data  (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests are noted before replies so that a same-edge reply would still
   // find its expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            shadow.note_request(lkv_pkg::op_type'(req_operation), req_key,
                                req_write_value);
         if (rsp_valid && rsp_ready)
            shadow.check_reply(rsp_found, rsp_read_value);
      end
   end

   task automatic offer_request(input lkv_pkg::op_type op, input lkv_pkg::key_type k,
                                input lkv_pkg::value_type v);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_key         <= k;
      req_write_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // Callers have already dropped req_valid.
   task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
      wait_for_drain();
      repeat (4) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_write_data <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow.set_capacity(cap);
      csr_valid <= 1'b0;
   endtask

   function automatic lkv_pkg::key_type pick_key();
      if ($urandom_range(0, 9) == 0) return lkv_pkg::key_type'($urandom);
      return key_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   // Mostly keys from a small pool, so that hits, updates and evictions are
   // frequent; about half the pool survives into the next phase.
   task automatic run_random_phase(input logic [lkv_pkg::CAP_W-1:0] cap, input int count);
      int remaining;
      int burst;
      write_capacity(cap);
      for (int i = 0; i < 24; i++) begin
         if ($urandom_range(0, 1) == 1) key_pool[i] = lkv_pkg::key_type'($urandom);
      end
      pool_size = $urandom_range(2, 24);
      remaining = count;
      while (remaining > 0) begin
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && remaining > 0; b++) begin
            offer_request($urandom_range(0, 1) ? lkv_pkg::OP_SET : lkv_pkg::OP_GET,
                          pick_key(), lkv_pkg::value_type'($urandom));
            remaining--;
         end
         if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 12));
      end
      req_valid <= 1'b0;
   endtask

   // The receiver alternates between free running, random stalls and solid
   // stalls, and takes one long hold-off when asked.
   initial begin
      int span;
      int mode;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_wanted) begin
            rsp_ready <= 1'b0;
            repeat (250) @(posedge clock);
            hold_off_wanted = 1'b0;
         end
         span = $urandom_range(1, 40);
         mode = $urandom_range(0, 2);
         repeat (span) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= 1'b0;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb_lru_key_value_cache: errors");
      $finish;
   end

   initial begin
      lkv_pkg::key_type ka;
      lkv_pkg::key_type kb;
      lkv_pkg::key_type kc;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= lkv_pkg::OP_GET;
      req_key         <= '0;
      req_write_value <= '0;
      csr_valid       <= 1'b0;
      csr_write_data  <= '0;
      for (int i = 0; i < 24; i++) key_pool[i] = lkv_pkg::key_type'($urandom);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Extremes of keys and values on an empty cache, then an overwrite.
      write_capacity(lkv_pkg::CAP_W'(16));
      offer_request(lkv_pkg::OP_GET, '0, '1);
      offer_request(lkv_pkg::OP_SET, '0, '0);
      offer_request(lkv_pkg::OP_SET, '1, '1);
      offer_request(lkv_pkg::OP_GET, '1, '0);
      offer_request(lkv_pkg::OP_GET, '0, '1);
      offer_request(lkv_pkg::OP_SET, '0, 32'h5a5a_a5a5);
      offer_request(lkv_pkg::OP_GET, '0, '0);
      offer_request(lkv_pkg::OP_GET, 32'h1234_5678, '0);
      req_valid <= 1'b0;

      // Two entries: recency decides which one a new key replaces.
      ka = lkv_pkg::key_type'($urandom);
      kb = ka ^ 32'h0000_0001;
      kc = ka ^ 32'h8000_0000;
      write_capacity(lkv_pkg::CAP_W'(2));
      offer_request(lkv_pkg::OP_SET, ka, 32'h1111_1111);
      offer_request(lkv_pkg::OP_SET, kb, 32'h2222_2222);
      offer_request(lkv_pkg::OP_GET, ka, '0);
      offer_request(lkv_pkg::OP_SET, kc, 32'h3333_3333);
      offer_request(lkv_pkg::OP_GET, kb, '0);
      offer_request(lkv_pkg::OP_GET, ka, '0);
      offer_request(lkv_pkg::OP_GET, kc, '0);
      offer_request(lkv_pkg::OP_SET, kb, 32'h4444_4444);
      offer_request(lkv_pkg::OP_GET, ka, '0);
      req_valid <= 1'b0;

      // A capacity of zero behaves as one, below the present occupancy.
      write_capacity('0);
      offer_request(lkv_pkg::OP_SET, ka, 32'h5555_5555);
      offer_request(lkv_pkg::OP_GET, kb, '0);
      offer_request(lkv_pkg::OP_GET, kc, '0);
      offer_request(lkv_pkg::OP_GET, ka, '0);
      req_valid <= 1'b0;

      run_random_phase(lkv_pkg::CAP_W'(16), 180);
      run_random_phase(lkv_pkg::CAP_W'(1), 150);
      // Drain first, so that the long hold-off falls while requests are offered.
      write_capacity('1);
      hold_off_wanted = 1'b1;
      run_random_phase('1, 200);
      run_random_phase(lkv_pkg::CAP_W'(17), 150);
      run_random_phase('0, 120);
      run_random_phase(lkv_pkg::CAP_W'(3), 150);
      run_random_phase(lkv_pkg::CAP_W'(16), 200);
      run_random_phase(lkv_pkg::CAP_W'($urandom_range(0, 31)), 150);
      run_random_phase(lkv_pkg::CAP_W'(8), 150);
      run_random_phase(lkv_pkg::CAP_W'(2), 100);
      run_random_phase(lkv_pkg::CAP_W'($urandom_range(1, 16)), 150);

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (shadow.mismatch_count == 0 && shadow.outstanding() == 0) begin
         $display("tb_lru_key_value_cache: clean");
      end else begin
         $display("tb_lru_key_value_cache: errors");
      end
      $finish;
   end

endmodule
